// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, skipped while reset is asserted.
`define AM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Condition that must never hold outside reset.
`define AM_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ----- src/me_pkg.sv -----
`default_nettype none

package me_pkg;

	localparam int OPERAND_BITS_DEF  = 32;
	localparam int EXPONENT_BITS_DEF = 40;

	typedef enum logic {
		MM_REDUCE,
		MM_MUL
	} mm_op_t;

	typedef struct packed {
		logic   start;
		mm_op_t op;
	} mm_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE_RUN,
		ST_SQ_ISSUE,
		ST_SQ_RUN,
		ST_MUL_ISSUE,
		ST_MUL_RUN,
		ST_WRITE
	} me_state_t;

endpackage

`default_nettype wire

// ----- src/modular_exponentiation.sv -----
// Sequence: the base is reduced mod the modulus, then for each of the E exponent bits, from the
// top, the accumulator is squared and, where the bit is one, multiplied by the reduced base;
// W = OPERAND_BITS, E = EXPONENT_BITS. A zero modulus skips straight to the write. The block
// holds one transaction at a time, each square or multiply run by the bit-serial modular unit
// through its issue and run states; the next input is taken once the sequencer is back in idle.
// Reset: arst_n clears the sequencer and the output valid; no result is pending after reset.
`default_nettype none
`include "assert_macros.svh"

module modular_exponentiation #(
	parameter int OPERAND_BITS  = me_pkg::OPERAND_BITS_DEF,
	parameter int EXPONENT_BITS = me_pkg::EXPONENT_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [OPERAND_BITS-1:0]  base,
	input  wire logic [EXPONENT_BITS-1:0] exponent,
	input  wire logic [OPERAND_BITS-1:0]  modulus,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [OPERAND_BITS-1:0]       power_residue
);

	localparam int BW = $clog2(EXPONENT_BITS + 1);

	me_pkg::me_state_t        state_q;
	me_pkg::me_state_t        state_d;
	logic [BW-1:0]            bits_q;
	logic [EXPONENT_BITS-1:0] exp_q;
	logic [OPERAND_BITS-1:0]  acc_q;
	logic [OPERAND_BITS-1:0]  base_q;
	logic [OPERAND_BITS-1:0]  mod_q;
	logic [OPERAND_BITS-1:0]  res_q;
	logic                     outv_q;

	me_pkg::mm_cmd_t          cmd;
	logic [OPERAND_BITS-1:0]  unit_x;
	logic [OPERAND_BITS-1:0]  unit_y;
	logic [OPERAND_BITS-1:0]  unit_m;
	logic                     unit_done;
	logic [OPERAND_BITS-1:0]  unit_res;

	logic                     accept;
	logic                     slot_free;
	logic                     exp_top;
	logic                     last_bit;

	assign in_stall  = (state_q != me_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !outv_q || !out_stall;
	assign exp_top   = exp_q[EXPONENT_BITS-1];
	assign last_bit  = (bits_q == BW'(1));

	me_modmul #(
		.W(OPERAND_BITS)
	) u_modmul (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.x     (unit_x),
		.y     (unit_y),
		.m     (unit_m),
		.done  (unit_done),
		.result(unit_res)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			me_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (modulus == '0) ? me_pkg::ST_WRITE : me_pkg::ST_BASE_RUN;
				end
			end
			me_pkg::ST_BASE_RUN: begin
				if (unit_done) begin
					state_d = me_pkg::ST_SQ_ISSUE;
				end
			end
			me_pkg::ST_SQ_ISSUE:  state_d = me_pkg::ST_SQ_RUN;
			me_pkg::ST_SQ_RUN: begin
				if (unit_done) begin
					if (exp_top) begin
						state_d = me_pkg::ST_MUL_ISSUE;
					end else begin
						state_d = last_bit ? me_pkg::ST_WRITE : me_pkg::ST_SQ_ISSUE;
					end
				end
			end
			me_pkg::ST_MUL_ISSUE: state_d = me_pkg::ST_MUL_RUN;
			me_pkg::ST_MUL_RUN: begin
				if (unit_done) begin
					state_d = last_bit ? me_pkg::ST_WRITE : me_pkg::ST_SQ_ISSUE;
				end
			end
			me_pkg::ST_WRITE: begin
				if (slot_free) begin
					state_d = me_pkg::ST_IDLE;
				end
			end
			default: state_d = me_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.start = 1'b0;
		cmd.op    = me_pkg::MM_MUL;
		unit_x    = acc_q;
		unit_y    = base_q;
		unit_m    = mod_q;
		unique case (state_q)
			me_pkg::ST_IDLE: begin
				// reduce the incoming base; a zero modulus skips the unit
				cmd.start = accept && (modulus != '0);
				cmd.op    = me_pkg::MM_REDUCE;
				unit_x    = '0;
				unit_y    = base;
				unit_m    = modulus;
			end
			me_pkg::ST_SQ_ISSUE: begin
				cmd.start = 1'b1;
				unit_y    = acc_q;
			end
			me_pkg::ST_MUL_ISSUE: begin
				cmd.start = 1'b1;
			end
			default: begin
				cmd.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= me_pkg::ST_IDLE;
			outv_q  <= 1'b0;
			bits_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == me_pkg::ST_WRITE && slot_free) begin
				outv_q <= 1'b1;
			end else if (!out_stall) begin
				outv_q <= 1'b0;
			end
			if (accept) begin
				bits_q <= BW'(EXPONENT_BITS);
			end else if (unit_done && ((state_q == me_pkg::ST_SQ_RUN && !exp_top) ||
					state_q == me_pkg::ST_MUL_RUN)) begin
				bits_q <= bits_q - BW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mod_q <= modulus;
			exp_q <= exponent;
			acc_q <= (modulus == '0 || modulus == OPERAND_BITS'(1)) ? '0 : OPERAND_BITS'(1);
		end
		if (state_q == me_pkg::ST_BASE_RUN && unit_done) begin
			base_q <= unit_res;
		end
		if (unit_done && (state_q == me_pkg::ST_SQ_RUN || state_q == me_pkg::ST_MUL_RUN)) begin
			acc_q <= unit_res;
			// drop the scanned exponent bit once its multiply, if any, is done
			if (state_q == me_pkg::ST_MUL_RUN || !exp_top) begin
				exp_q <= {exp_q[EXPONENT_BITS-2:0], 1'b0};
			end
		end
		if (state_q == me_pkg::ST_WRITE && slot_free) begin
			res_q <= acc_q;
		end
	end

	assign out_valid     = outv_q;
	assign power_residue = res_q;

	`AM_NEVER(a_bits_live, clk, arst_n,
		(state_q == me_pkg::ST_SQ_ISSUE || state_q == me_pkg::ST_MUL_ISSUE) && bits_q == '0)
	`AM_ASSERT(a_acc_range, clk, arst_n, (state_q == me_pkg::ST_SQ_ISSUE) |-> acc_q < mod_q)

endmodule

`default_nettype wire

// ----- src/me_modmul.sv -----
`default_nettype none
`include "assert_macros.svh"

// Bit-serial modular unit: one add and conditional subtract per cycle.
// MM_MUL:    result = x * y mod m, doubling and adding on alternate cycles.
// MM_REDUCE: result = y mod m, shifting y in one bit per cycle.
module me_modmul #(
	parameter int W = me_pkg::OPERAND_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire me_pkg::mm_cmd_t cmd,
	input  wire logic [W-1:0]   x,
	input  wire logic [W-1:0]   y,
	input  wire logic [W-1:0]   m,
	output logic                done,
	output logic [W-1:0]        result
);

	localparam int CW = $clog2(2 * W + 1);

	logic            busy_q;
	logic            done_q;
	logic            phase_q;
	me_pkg::mm_op_t  op_q;
	logic [CW-1:0]   cnt_q;
	logic [W-1:0]    r_q;
	logic [W-1:0]    x_q;
	logic [W-1:0]    y_q;
	logic [W-1:0]    m_q;

	logic            ybit;
	logic            is_add;
	logic [W-1:0]    addend;
	logic            cin;
	logic [W:0]      sum;
	logic [W:0]      diff;
	logic [W-1:0]    r_next;
	logic            last;

	always_comb begin
		ybit   = y_q[W-1];
		is_add = (op_q == me_pkg::MM_MUL) && phase_q;
		if (is_add) begin
			addend = ybit ? x_q : '0;
			cin    = 1'b0;
		end else begin
			addend = r_q;
			cin    = (op_q == me_pkg::MM_REDUCE) ? ybit : 1'b0;
		end
		sum    = {1'b0, r_q} + {1'b0, addend} + {{W{1'b0}}, cin};
		diff   = sum - {1'b0, m_q};
		r_next = (sum >= {1'b0, m_q}) ? diff[W-1:0] : sum[W-1:0];
		last   = (cnt_q == CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			op_q    <= me_pkg::MM_REDUCE;
			cnt_q   <= '0;
		end else if (cmd.start) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			op_q    <= cmd.op;
			cnt_q   <= (cmd.op == me_pkg::MM_MUL) ? CW'(2 * W) : CW'(W);
		end else if (busy_q) begin
			cnt_q   <= cnt_q - CW'(1);
			phase_q <= (op_q == me_pkg::MM_MUL) ? !phase_q : 1'b0;
			busy_q  <= !last;
			done_q  <= last;
		end else begin
			done_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			r_q <= '0;
			x_q <= x;
			y_q <= y;
			m_q <= m;
		end else if (busy_q) begin
			r_q <= r_next;
			// advance the scanned operand once its bit is consumed
			if (op_q == me_pkg::MM_REDUCE || phase_q) begin
				y_q <= {y_q[W-2:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign result = r_q;

	`AM_ASSERT(a_no_restart, clk, arst_n, cmd.start |-> !busy_q)
	`AM_ASSERT(a_result_reduced, clk, arst_n, (done_q && m_q != '0) |-> r_q < m_q)
	`AM_ASSERT(a_done_pulse, clk, arst_n, done_q |=> !done_q)

endmodule

`default_nettype wire

// ----- dv/me_result_monitor.sv -----
module me_result_monitor #(
	parameter int OW = me_pkg::OPERAND_BITS_DEF,
	parameter int EW = me_pkg::EXPONENT_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_stall,
	input  wire logic [OW-1:0] base,
	input  wire logic [EW-1:0] exponent,
	input  wire logic [OW-1:0] modulus,
	input  wire logic          out_valid,
	input  wire logic          out_stall,
	input  wire logic [OW-1:0] power_residue,
	output int                 mismatches,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [OW-1:0] b;
		logic [EW-1:0] e;
		logic [OW-1:0] m;
		logic [OW-1:0] residue;
	} request_t;

	request_t pending_residues[$];

	// Square and multiply from the top exponent bit down; products fit in 2*OW bits.
	function automatic logic [OW-1:0] modexp_residue(
		input logic [OW-1:0] b,
		input logic [EW-1:0] e,
		input logic [OW-1:0] m
	);
		logic [2*OW-1:0] acc;
		logic [2*OW-1:0] reduced_base;
		logic [2*OW-1:0] wide_m;
		if (m == '0)
			return '0;
		wide_m = {{OW{1'b0}}, m};
		reduced_base = {{OW{1'b0}}, b} % wide_m;
		acc = (m == OW'(1)) ? '0 : (2*OW)'(1);
		for (int i = EW - 1; i >= 0; i--) begin
			acc = (acc * acc) % wide_m;
			if (e[i])
				acc = (acc * reduced_base) % wide_m;
		end
		return acc[OW-1:0];
	endfunction

	initial begin
		request_t req;
		request_t due;
		int delta;
		mismatches = 0;
		outstanding = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				delta = 0;
				// Retire the result before logging a new request taken on the same edge.
				if (out_valid && !out_stall) begin
					if (pending_residues.size() == 0) begin
						$display("%0t: result %0d arrived with no request waiting",
							$time, power_residue);
						mismatches++;
					end else begin
						due = pending_residues.pop_front();
						delta--;
						if (power_residue !== due.residue) begin
							$display("%0t: %0d ^ %0d mod %0d: expected %0d, got %0d",
								$time, due.b, due.e, due.m, due.residue, power_residue);
							mismatches++;
						end
					end
				end
				if (in_valid && !in_stall) begin
					req.b = base;
					req.e = exponent;
					req.m = modulus;
					req.residue = modexp_residue(base, exponent, modulus);
					pending_residues.push_back(req);
					delta++;
				end
				outstanding <= outstanding + delta;
			end
		end
	end

endmodule

// ----- dv/tb_modular_exponentiation.sv -----
module tb_modular_exponentiation;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OW = me_pkg::OPERAND_BITS_DEF;
	localparam int EW = me_pkg::EXPONENT_BITS_DEF;
	localparam logic [OW-1:0] OP_MAX  = '1;
	localparam logic [EW-1:0] EXP_MAX = '1;
	localparam int RANDOM_ITEMS = 90;
	localparam int START_HOLD   = 12000;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	logic [OW-1:0] base;
	logic [EW-1:0] exponent;
	logic [OW-1:0] modulus;
	logic          out_valid;
	logic          out_stall;
	logic [OW-1:0] power_residue;
	int            mismatches;
	int            outstanding;
	int            burst_left;

	modular_exponentiation #(
		.OPERAND_BITS (OW),
		.EXPONENT_BITS(EW)
	) dut (.*);

	me_result_monitor #(
		.OW(OW),
		.EW(EW)
	) monitor (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("modular_exponentiation test failed");
		$finish;
	end

	// Hold results back from the start so the block backs up, then stall on shifting patterns.
	initial begin
		int held;
		int span;
		int mode;
		out_stall = 1'b1;
		for (held = 0; held < START_HOLD; held++)
			@(posedge clk);
		forever begin
			mode = $urandom_range(3);
			span = $urandom_range(20, 300);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(3) == 0);
					2: out_stall <= ($urandom_range(1) == 1);
					default: out_stall <= ($urandom_range(9) != 0);
				endcase
			end
		end
	end

	task automatic offer(
		input logic [OW-1:0] b,
		input logic [EW-1:0] e,
		input logic [OW-1:0] m
	);
		int gap;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 24);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
		end
		base <= b;
		exponent <= e;
		modulus <= m;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		burst_left--;
	endtask

	// Stop offering until every transaction in flight has returned.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		burst_left = 0;
	endtask

	task automatic offer_random();
		logic [63:0]   wide;
		logic [OW-1:0] b;
		logic [EW-1:0] e;
		logic [OW-1:0] m;
		wide = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: e = wide[EW-1:0];
			6, 7: e = EW'($urandom_range(0, 300));
			8: e = EW'(1) << $urandom_range(0, EW - 1);
			default: e = ($urandom_range(1) == 1) ? EXP_MAX : '0;
		endcase
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: m = $urandom;
			6: m = OW'($urandom_range(1, 16));
			7: m = OW'(1) << $urandom_range(0, OW - 1);
			8: m = OP_MAX - OW'($urandom_range(0, 20));
			default: m = ($urandom_range(3) == 0) ? '0 : OW'($urandom_range(2, 1000));
		endcase
		case ($urandom_range(5))
			0: b = OW'($urandom_range(0, 3));
			1: b = OP_MAX - OW'($urandom_range(0, 3));
			default: b = $urandom;
		endcase
		offer(b, e, m);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		base = '0;
		exponent = '0;
		modulus = '0;
		burst_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(OP_MAX, EXP_MAX, OP_MAX);
		offer(OP_MAX - OW'(1), EXP_MAX, OP_MAX);
		offer('0, '0, OW'(1));
		offer('0, '0, OW'(5));
		offer('0, EW'(1), OW'(7));
		offer(OP_MAX, EW'(1), OP_MAX);
		offer(OP_MAX, EW'(2), OW'(2));
		offer(OW'(12345), '0, OP_MAX);
		offer(OW'(3), EXP_MAX, OW'(1));
		offer(OP_MAX, EXP_MAX, '0);
		offer('0, '0, '0);
		offer(OW'(7), EW'(1) << (EW - 1), OW'(13));
		offer(OW'(5), EW'(1), OW'(2));
		offer(OW'(123456789), {(EW / 2){2'b01}}, OW'(1000000007));
		offer(OW'(1000), EW'(3), OW'(7));
		offer(OW'(2), EW'(OW - 1), OW'(1) << (OW - 1));
		offer(OP_MAX, {(EW / 2){2'b10}}, OW'(1) << (OW - 1) | OW'(1));
		offer(OW'(2), EXP_MAX, OW'(4294967291));
		offer(OW'(1), EXP_MAX, OP_MAX);
		offer(OP_MAX, EXP_MAX, OW'(3));
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				drain();
			offer_random();
		end
		drain();
		repeat (100) @(posedge clk);

		if (mismatches == 0)
			$display("modular_exponentiation test passed");
		else
			$display("modular_exponentiation test failed");
		$finish;
	end

endmodule
